// ===== design/mlcm_pkg.sv =====
package mlcm_pkg;

   localparam int LEVEL_BITS      = 16;
   localparam int CHANNEL_SLOTS   = 17;
   localparam int NUM_SLOTS       = 128;
   localparam int TABLE_DEPTH     = 2 * CHANNEL_SLOTS * NUM_SLOTS;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int DIV_CNT_W       = $clog2(LEVEL_BITS + 1);
   localparam int MAX_TYPE        = 20;
   localparam int MAX_DECK        = 2;
   localparam int LEARN_RANGE_MAX = 127;
   localparam int TIMEOUT_RESET   = 10000;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   localparam logic [2:0] FUNC_MIDI   = 3'd0;
   localparam logic [2:0] FUNC_ARM    = 3'd1;
   localparam logic [2:0] FUNC_TICK   = 3'd2;
   localparam logic [2:0] FUNC_ADD    = 3'd3;
   localparam logic [2:0] FUNC_REMOVE = 3'd4;
   localparam logic [2:0] FUNC_CLEAR  = 3'd5;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_MAPPED   = 2'd1;
   localparam logic [1:0] KIND_LEARNED  = 2'd2;
   localparam logic [1:0] KIND_UNMAPPED = 2'd3;

   localparam logic [1:0] PATH_DIRECT = 2'd0;
   localparam logic [1:0] PATH_OMNI   = 2'd1;
   localparam logic [1:0] PATH_SCAN   = 2'd2;

   localparam logic [1:0] REG_ENGINE_ENABLE  = 2'd0;
   localparam logic [1:0] REG_GLOBAL_CHANNEL = 2'd1;
   localparam logic [1:0] REG_LEARN_ENABLE   = 2'd2;
   localparam logic [1:0] REG_LEARN_TIMEOUT  = 2'd3;

   typedef struct packed {
      logic [2:0] func;
      logic [4:0] channel;
      logic       is_note;
      logic [6:0] number;
      logic [6:0] value;
      logic [4:0] control_type;
      logic [1:0] deck;
      logic [6:0] range_min;
      logic [6:0] range_max;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          hit_path;
      logic [4:0]          out_control_type;
      logic [1:0]          out_deck;
      logic [LEVEL_BITS:0] level;
      logic                pressed;
      logic [4:0]          echo_channel;
      logic [6:0]          echo_number;
      logic [6:0]          echo_value;
      logic                echo_is_note;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] ctype;
      logic [1:0] deck;
      logic [6:0] lo;
      logic [6:0] hi;
   } entry_type;

   typedef struct packed {
      logic        engine_enable;
      logic [4:0]  global_channel;
      logic        learn_enable;
      logic [15:0] learn_timeout_ticks;
      logic        learn_clear;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic check;
      logic div_run;
      logic clear_step;
   } ctrl_type;

   typedef struct packed {
      logic do_lookup;
      logic do_clear;
      logic hit;
      logic more;
      logic div_done;
      logic clear_last;
   } stat_type;

   function automatic logic [4:0] clean_type(input logic [4:0] t);
      return (t > 5'(MAX_TYPE)) ? 5'd0 : t;
   endfunction

   function automatic logic [1:0] clean_deck(input logic [1:0] d);
      return (d > 2'(MAX_DECK)) ? 2'd0 : d;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic note, input logic [4:0] ch,
                                                   input logic [6:0] num);
      return ADDR_W'({ch, num}) + (note ? ADDR_W'(CHANNEL_SLOTS * NUM_SLOTS) : ADDR_W'(0));
   endfunction

endpackage

// ===== design/mlcm_ctrl.sv =====
module mlcm_ctrl
   import mlcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     busy,
   output logic     rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:   if (stat.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            if (stat.do_clear) state_in = ST_CLEAR;
            else if (stat.do_lookup) state_in = ST_READ;
            else state_in = ST_DONE;
         end
         ST_READ:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.hit) state_in = ST_DIV;
            else if (stat.more) state_in = ST_READ;
            else state_in = ST_DONE;
         end
         ST_DIV:    if (stat.div_done) state_in = ST_DONE;
         ST_CLEAR:  if (stat.clear_last) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      busy            = 1'b1;
      rsp_valid       = 1'b0;
      unique case (state_ff)
         ST_INIT:   ctrl.clear_step = 1'b1;
         ST_IDLE: begin
            busy       = 1'b0;
            ctrl.latch = start;
         end
         ST_DECODE: ctrl.exec = 1'b1;
         ST_READ:   ;
         ST_CHECK:  ctrl.check = 1'b1;
         ST_DIV:    ctrl.div_run = 1'b1;
         ST_CLEAR:  ctrl.clear_step = 1'b1;
         ST_DONE:   rsp_valid = 1'b1;
         default:   ;
      endcase
   end

endmodule

// ===== design/mlcm_datapath.sv =====
module mlcm_datapath
   import mlcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cfg_type  cfg,
   input  ctrl_type ctrl,
   output stat_type stat,
   output rsp_type  rsp_data
);

   entry_type mem_ram [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic                  we;
   logic [ADDR_W-1:0]     wa;
   entry_type             wd;
   logic [ADDR_W-1:0]     rd_addr;

   req_type               req_ff;
   rsp_type               rsp_ff;
   logic [4:0]            pend_type_ff;
   logic [1:0]            pend_deck_ff;
   logic [15:0]           countdown_ff;
   logic [4:0]            probe_ch_ff;
   logic [1:0]            path_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;
   logic [6:0]            ad_ff;
   logic [6:0]            rem_ff;
   logic [LEVEL_BITS-1:0] quot_ff;
   logic                  use_div_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;

   logic                  ch_ok;
   logic                  msg_ok;
   logic                  midi_ok;
   logic                  learn_hit;
   logic                  learned;
   logic signed [7:0]     num_s;
   logic signed [7:0]     den_s;
   logic [6:0]            an;
   logic [6:0]            ad;
   logic [7:0]            rem2;
   logic                  qbit;

   localparam logic [LEVEL_BITS:0] LEVEL_ONE  = (LEVEL_BITS + 1)'(1) << LEVEL_BITS;
   localparam logic [LEVEL_BITS:0] LEVEL_HALF = (LEVEL_BITS + 1)'(1) << (LEVEL_BITS - 1);

   assign ch_ok     = req_ff.channel < 5'(CHANNEL_SLOTS);
   assign msg_ok    = cfg.engine_enable && ch_ok;
   assign midi_ok   = (req_ff.func == FUNC_MIDI) && msg_ok;
   assign learn_hit = msg_ok && cfg.learn_enable && (pend_type_ff != 5'd0);
   assign learned   = midi_ok && learn_hit;

   assign stat.do_lookup  = (req_ff.func == FUNC_MIDI) && msg_ok && !learn_hit;
   assign stat.do_clear   = (req_ff.func == FUNC_CLEAR);
   assign stat.hit        = rd_data_ff.valid;
   assign stat.more       = (path_ff == PATH_DIRECT) ||
                            (path_ff == PATH_OMNI && cfg.global_channel == 5'd0) ||
                            (path_ff == PATH_SCAN && probe_ch_ff < 5'(CHANNEL_SLOTS - 1));
   assign stat.div_done   = div_cnt_ff == DIV_CNT_W'(LEVEL_BITS);
   assign stat.clear_last = clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1);

   always_comb begin
      we = 1'b0;
      wa = slot_addr(req_ff.is_note, req_ff.channel, req_ff.number);
      wd = '0;
      if (ctrl.clear_step) begin
         we = 1'b1;
         wa = clr_addr_ff;
      end else if (ctrl.exec) begin
         unique case (req_ff.func)
            FUNC_MIDI: begin
               if (learn_hit) begin
                  we = 1'b1;
                  wd = '{valid: 1'b1, ctype: pend_type_ff, deck: pend_deck_ff,
                         lo: 7'd0, hi: 7'(LEARN_RANGE_MAX)};
               end
            end
            FUNC_ADD: begin
               if (ch_ok) begin
                  we = 1'b1;
                  wd = '{valid: 1'b1, ctype: clean_type(req_ff.control_type),
                         deck: clean_deck(req_ff.deck), lo: req_ff.range_min,
                         hi: req_ff.range_max};
               end
            end
            FUNC_REMOVE: we = ch_ok;
            default: ;
         endcase
      end
   end

   assign rd_addr = slot_addr(req_ff.is_note, probe_ch_ff, req_ff.number);

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ram[wa] <= wd;
      end
      rd_data_ff <= mem_ram[rd_addr];
   end

   // Operand signs and magnitudes of the level ratio, and the divider's next quotient bit.
   always_comb begin
      num_s = $signed({1'b0, req_ff.value}) - $signed({1'b0, rd_data_ff.lo});
      den_s = $signed({1'b0, rd_data_ff.hi}) - $signed({1'b0, rd_data_ff.lo});
      an    = num_s[7] ? 7'(-num_s) : num_s[6:0];
      ad    = den_s[7] ? 7'(-den_s) : den_s[6:0];
      rem2  = {rem_ff, 1'b0};
      qbit  = rem2 >= {1'b0, ad_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_type_ff <= '0;
         pend_deck_ff <= '0;
         countdown_ff <= '0;
         clr_addr_ff  <= '0;
      end else begin
         if (ctrl.clear_step) begin
            clr_addr_ff <= stat.clear_last ? '0 : clr_addr_ff + ADDR_W'(1);
         end
         if (cfg.learn_clear) begin
            pend_type_ff <= '0;
            pend_deck_ff <= '0;
            countdown_ff <= '0;
         end else if (ctrl.exec) begin
            unique case (req_ff.func)
               FUNC_MIDI: begin
                  if (learn_hit) begin
                     pend_type_ff <= '0;
                     pend_deck_ff <= '0;
                     countdown_ff <= '0;
                  end
               end
               FUNC_ARM: begin
                  if (cfg.learn_enable) begin
                     pend_type_ff <= clean_type(req_ff.control_type);
                     pend_deck_ff <= clean_deck(req_ff.deck);
                     countdown_ff <= cfg.learn_timeout_ticks;
                  end
               end
               FUNC_TICK: begin
                  if (pend_type_ff == 5'd0) begin
                     countdown_ff <= '0;
                  end else if (countdown_ff <= 16'd1) begin
                     pend_type_ff <= '0;
                     pend_deck_ff <= '0;
                     countdown_ff <= '0;
                  end else begin
                     countdown_ff <= countdown_ff - 16'd1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         req_ff <= req_data;
      end
      if (ctrl.exec) begin
         probe_ch_ff             <= req_ff.channel;
         path_ff                 <= PATH_DIRECT;
         rsp_ff.kind             <= learned ? KIND_LEARNED : KIND_NONE;
         rsp_ff.hit_path         <= PATH_DIRECT;
         rsp_ff.out_control_type <= learned ? pend_type_ff : 5'd0;
         rsp_ff.out_deck         <= learned ? pend_deck_ff : 2'd0;
         rsp_ff.level            <= '0;
         rsp_ff.pressed          <= 1'b0;
         rsp_ff.echo_channel     <= midi_ok ? req_ff.channel : 5'd0;
         rsp_ff.echo_number      <= midi_ok ? req_ff.number : 7'd0;
         rsp_ff.echo_value       <= midi_ok ? req_ff.value : 7'd0;
         rsp_ff.echo_is_note     <= midi_ok && req_ff.is_note;
      end
      if (ctrl.check) begin
         if (rd_data_ff.valid) begin
            rsp_ff.kind             <= KIND_MAPPED;
            rsp_ff.hit_path         <= path_ff;
            rsp_ff.out_control_type <= rd_data_ff.ctype;
            rsp_ff.out_deck         <= rd_data_ff.deck;
            div_cnt_ff              <= '0;
            quot_ff                 <= '0;
            ad_ff                   <= ad;
            rem_ff                  <= an;
            if (den_s == 8'sd0) begin
               rsp_ff.level <= num_s[7] ? '0 : LEVEL_ONE;
               use_div_ff   <= 1'b0;
            end else if (num_s == 8'sd0 || num_s[7] != den_s[7]) begin
               rsp_ff.level <= '0;
               use_div_ff   <= 1'b0;
            end else if (an >= ad) begin
               rsp_ff.level <= LEVEL_ONE;
               use_div_ff   <= 1'b0;
            end else begin
               rsp_ff.level <= '0;
               use_div_ff   <= 1'b1;
            end
         end else if (stat.more) begin
            if (path_ff == PATH_SCAN) begin
               probe_ch_ff <= probe_ch_ff + 5'd1;
            end else begin
               probe_ch_ff <= 5'd0;
               path_ff     <= (path_ff == PATH_DIRECT) ? PATH_OMNI : PATH_SCAN;
            end
         end else begin
            rsp_ff.kind <= KIND_UNMAPPED;
         end
      end
      if (ctrl.div_run) begin
         if (!stat.div_done) begin
            rem_ff     <= qbit ? 7'(rem2 - {1'b0, ad_ff}) : rem2[6:0];
            quot_ff    <= {quot_ff[LEVEL_BITS-2:0], qbit};
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end else if (use_div_ff) begin
            rsp_ff.level <= {1'b0, quot_ff};
         end
      end
   end

   always_comb begin
      rsp_data         = rsp_ff;
      rsp_data.pressed = rsp_ff.level > LEVEL_HALF;
   end

endmodule

// ===== design/midi_learn_control_mapper_core.sv =====
// MIDI learn control mapper. Items are commands (message, arm learn, tick, add, remove,
// clear all); an item is taken when start is high and busy is low, and every item gives
// exactly one result, shown on rsp_data for a single cycle while rsp_valid is high. The
// receiver cannot hold results off, so it must take each result in the cycle it appears.
// Timing is set by the registered read of the mapping memory and the bit-serial divider.
// A command without a table lookup is decoded and then shows its result. A message lookup
// reads and checks one table probe at a time (direct, channel-0 omni, then up to 17
// channels in omni mode); on a hit the divider then forms the level before the result is
// shown, and on a miss the result follows the last probe. Clear all sweeps the 4352-entry
// table one entry a cycle. After reset the block is busy while the same clearing pass runs;
// configuration writes are taken at any time.
module midi_learn_control_mapper_core
   import mlcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Configuration registers, one 32-bit word each.
   logic        engine_enable_ff;
   logic [4:0]  global_channel_ff;
   logic        learn_enable_ff;
   logic [15:0] learn_timeout_ff;
   logic        csr_write;
   logic [1:0]  csr_index;
   cfg_type     cfg;
   ctrl_type    ctrl;
   stat_type    stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         engine_enable_ff  <= 1'b0;
         global_channel_ff <= 5'd1;
         learn_enable_ff   <= 1'b0;
         learn_timeout_ff  <= 16'(TIMEOUT_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ENGINE_ENABLE:  engine_enable_ff  <= pwdata[0];
            REG_GLOBAL_CHANNEL: global_channel_ff <= pwdata[4:0];
            REG_LEARN_ENABLE:   learn_enable_ff   <= pwdata[0];
            REG_LEARN_TIMEOUT:  learn_timeout_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENGINE_ENABLE:  prdata = CSR_DATA_W'(engine_enable_ff);
         REG_GLOBAL_CHANNEL: prdata = CSR_DATA_W'(global_channel_ff);
         REG_LEARN_ENABLE:   prdata = CSR_DATA_W'(learn_enable_ff);
         REG_LEARN_TIMEOUT:  prdata = CSR_DATA_W'(learn_timeout_ff);
         default:            prdata = '0;
      endcase
   end

   // Writing zero to the learn enable drops any pending learn arm in the same edge.
   always_comb begin
      cfg.engine_enable       = engine_enable_ff;
      cfg.global_channel      = global_channel_ff;
      cfg.learn_enable        = learn_enable_ff;
      cfg.learn_timeout_ticks = learn_timeout_ff;
      cfg.learn_clear         = csr_write && (csr_index == REG_LEARN_ENABLE) && !pwdata[0];
   end

   mlcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mlcm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/midi_learn_control_mapper_core_tb.sv =====
module midi_learn_control_mapper_core_tb;
   import mlcm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A clear-all sweep is the longest kind of item; the limit below is several times the run
   // in which every item were a clear-all.
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam int     DRAIN_WAIT  = 100;
   localparam int     RANDOM_ITEMS = 185;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   midi_learn_control_mapper_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the block's state, kept in step with every accepted item.
   typedef struct packed {
      logic       used;
      logic [4:0] ctype;
      logic [1:0] deck;
      logic [6:0] lo;
      logic [6:0] hi;
   } mapping_type;

   mapping_type mappings [TABLE_DEPTH];
   logic [4:0]  armed_type = '0;
   logic [1:0]  armed_deck = '0;
   logic [15:0] learn_count = '0;
   logic        engine_on = 1'b0;
   logic [4:0]  sel_channel = 5'd1;
   logic        learn_on = 1'b0;
   logic [15:0] learn_ticks = 16'(TIMEOUT_RESET);

   req_type pending_cmds [$];
   rsp_type awaited_events [$];
   int      failures = 0;
   int      idle_pct = 0;
   longint  cycles = 0;
   logic    taken = 1'b0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      failures++;
   endtask

   function automatic int map_index(input logic note, input logic [4:0] ch,
                                    input logic [6:0] num);
      return (int'(note) * CHANNEL_SLOTS + int'(ch)) * NUM_SLOTS + int'(num);
   endfunction

   function automatic logic [4:0] legal_type(input logic [4:0] t);
      return (t > 5'(MAX_TYPE)) ? 5'd0 : t;
   endfunction

   function automatic logic [1:0] legal_deck(input logic [1:0] d);
      return (d == 2'd3) ? 2'd0 : d;
   endfunction

   // Normalised level: (value - lo) / (hi - lo) in LEVEL_BITS fixed point,
   // truncated and clamped to [0, 1.0].
   function automatic logic [LEVEL_BITS:0] scaled_level(input logic [6:0] v,
                                                        input logic [6:0] lo,
                                                        input logic [6:0] hi);
      int     num;
      int     den;
      longint an;
      longint ad;
      logic [LEVEL_BITS:0] one;
      one = (LEVEL_BITS + 1)'(1) << LEVEL_BITS;
      num = int'(v) - int'(lo);
      den = int'(hi) - int'(lo);
      if (den == 0) return (num >= 0) ? one : '0;
      if (num == 0 || ((num < 0) != (den < 0))) return '0;
      an = longint'((num < 0) ? -num : num);
      ad = longint'((den < 0) ? -den : den);
      if (an >= ad) return one;
      return (LEVEL_BITS + 1)'((an << LEVEL_BITS) / ad);
   endfunction

   // Works out the single event an accepted command gives and updates the shadow state.
   function automatic rsp_type predict_event(input req_type r);
      rsp_type     e;
      int          idx;
      int          c;
      bit          found;
      mapping_type m;
      e = '0;
      found = 0;
      case (r.func)
         FUNC_MIDI: begin
            if (engine_on && r.channel < 5'(CHANNEL_SLOTS)) begin
               e.echo_channel = r.channel;
               e.echo_number  = r.number;
               e.echo_value   = r.value;
               e.echo_is_note = r.is_note;
               idx = map_index(r.is_note, r.channel, r.number);
               if (learn_on && armed_type != 0) begin
                  mappings[idx] = '{1'b1, armed_type, armed_deck, 7'd0, 7'(LEARN_RANGE_MAX)};
                  e.kind = KIND_LEARNED;
                  e.out_control_type = armed_type;
                  e.out_deck = armed_deck;
                  armed_type = '0;
                  armed_deck = '0;
                  learn_count = '0;
               end else begin
                  if (mappings[idx].used) begin
                     m = mappings[idx];
                     found = 1;
                     e.hit_path = PATH_DIRECT;
                  end else if (mappings[map_index(r.is_note, 5'd0, r.number)].used) begin
                     m = mappings[map_index(r.is_note, 5'd0, r.number)];
                     found = 1;
                     e.hit_path = PATH_OMNI;
                  end else if (sel_channel == 0) begin
                     for (c = 0; c < CHANNEL_SLOTS && !found; c++) begin
                        if (mappings[map_index(r.is_note, 5'(c), r.number)].used) begin
                           m = mappings[map_index(r.is_note, 5'(c), r.number)];
                           found = 1;
                           e.hit_path = PATH_SCAN;
                        end
                     end
                  end
                  if (!found) begin
                     e.kind = KIND_UNMAPPED;
                  end else begin
                     e.kind = KIND_MAPPED;
                     e.out_control_type = m.ctype;
                     e.out_deck = m.deck;
                     e.level = scaled_level(r.value, m.lo, m.hi);
                     e.pressed = (e.level > (1 << (LEVEL_BITS - 1)));
                  end
               end
            end
         end
         FUNC_ARM: begin
            if (learn_on) begin
               armed_type = legal_type(r.control_type);
               armed_deck = legal_deck(r.deck);
               learn_count = learn_ticks;
            end
         end
         FUNC_TICK: begin
            if (armed_type == 0) begin
               learn_count = '0;
            end else if (learn_count <= 1) begin
               armed_type = '0;
               armed_deck = '0;
               learn_count = '0;
            end else begin
               learn_count = learn_count - 1'b1;
            end
         end
         FUNC_ADD: begin
            if (r.channel < 5'(CHANNEL_SLOTS))
               mappings[map_index(r.is_note, r.channel, r.number)] =
                  '{1'b1, legal_type(r.control_type), legal_deck(r.deck),
                    r.range_min, r.range_max};
         end
         FUNC_REMOVE: begin
            if (r.channel < 5'(CHANNEL_SLOTS))
               mappings[map_index(r.is_note, r.channel, r.number)] = '0;
         end
         FUNC_CLEAR: begin
            foreach (mappings[i]) mappings[i] = '0;
         end
         default: ;
      endcase
      return e;
   endfunction

   // Input side and result side both sampled at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
      taken <= start && !busy && !reset;
      if (start && !busy && !reset) awaited_events.push_back(predict_event(req_data));
      if (rsp_valid && !reset) begin
         if (awaited_events.size() == 0) begin
            report_mismatch("event with none outstanding");
         end else begin
            want = awaited_events.pop_front();
            if (rsp_data.kind != want.kind)
               report_mismatch($sformatf("kind %0d, wanted %0d", rsp_data.kind, want.kind));
            if (rsp_data.hit_path != want.hit_path)
               report_mismatch($sformatf("hit_path %0d, wanted %0d",
                                         rsp_data.hit_path, want.hit_path));
            if (rsp_data.out_control_type != want.out_control_type)
               report_mismatch($sformatf("control type %0d, wanted %0d",
                                         rsp_data.out_control_type, want.out_control_type));
            if (rsp_data.out_deck != want.out_deck)
               report_mismatch($sformatf("deck %0d, wanted %0d",
                                         rsp_data.out_deck, want.out_deck));
            if (rsp_data.level != want.level)
               report_mismatch($sformatf("level %0d, wanted %0d", rsp_data.level, want.level));
            if (rsp_data.pressed != want.pressed)
               report_mismatch($sformatf("pressed %0d, wanted %0d",
                                         rsp_data.pressed, want.pressed));
            if (rsp_data.echo_channel != want.echo_channel)
               report_mismatch($sformatf("echo channel %0d, wanted %0d",
                                         rsp_data.echo_channel, want.echo_channel));
            if (rsp_data.echo_number != want.echo_number)
               report_mismatch($sformatf("echo number %0d, wanted %0d",
                                         rsp_data.echo_number, want.echo_number));
            if (rsp_data.echo_value != want.echo_value)
               report_mismatch($sformatf("echo value %0d, wanted %0d",
                                         rsp_data.echo_value, want.echo_value));
            if (rsp_data.echo_is_note != want.echo_is_note)
               report_mismatch($sformatf("echo note flag %0d, wanted %0d",
                                         rsp_data.echo_is_note, want.echo_is_note));
         end
      end
   end

   // The command driver changes inputs at the falling edge. An offered item is held
   // until the edge that takes it; only then may a gap or the next item follow.
   always @(negedge clock) begin
      if (!reset && (!start || taken)) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Callers must make register writes only while the block is idle (this task does not enforce
   // it), so the shadow copy can be updated straight after the access edge.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * idx);
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_ENGINE_ENABLE:  engine_on = val[0];
         REG_GLOBAL_CHANNEL: sel_channel = val[4:0];
         REG_LEARN_ENABLE: begin
            learn_on = val[0];
            if (!val[0]) begin
               armed_type = '0;
               armed_deck = '0;
               learn_count = '0;
            end
         end
         default: learn_ticks = val[15:0];
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || awaited_events.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic req_type cmd(input logic [2:0] f, input logic [4:0] ch,
                                   input logic note, input logic [6:0] num,
                                   input logic [6:0] val, input logic [4:0] ct,
                                   input logic [1:0] dk, input logic [6:0] mn,
                                   input logic [6:0] mx);
      return '{f, ch, note, num, val, ct, dk, mn, mx};
   endfunction

   // Random commands mostly aim at a handful of numbers and legal channels so that
   // lookups hit, learn arms complete and every lookup path is exercised.
   function automatic req_type random_cmd();
      req_type r;
      int      pick;
      int      nums [4] = '{0, 1, 2, 127};
      r = req_type'($bits(req_type)'({$urandom, $urandom}));
      pick = $urandom_range(999);
      if      (pick < 420) r.func = FUNC_MIDI;
      else if (pick < 620) r.func = FUNC_ADD;
      else if (pick < 700) r.func = FUNC_REMOVE;
      else if (pick < 820) r.func = FUNC_ARM;
      else if (pick < 985) r.func = FUNC_TICK;
      else if (pick < 990) r.func = FUNC_CLEAR;
      else                 r.func = 3'($urandom_range(7, 6));
      if ($urandom_range(99) < 88) r.channel = 5'($urandom_range(16));
      if ($urandom_range(99) < 80) r.number = 7'(nums[$urandom_range(3)]);
      return r;
   endfunction

   task automatic run_random(input int pct);
      idle_pct = pct;
      repeat (RANDOM_ITEMS) pending_cmds.push_back(random_cmd());
      wait_drained();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed part: engine on, omni scan, learn on, a short learn timeout.
      csr_write(REG_ENGINE_ENABLE, 32'd1);
      csr_write(REG_GLOBAL_CHANNEL, 32'd0);
      csr_write(REG_LEARN_ENABLE, 32'd1);
      csr_write(REG_LEARN_TIMEOUT, 32'd2);
      // Direct hit at both ends of the range.
      pending_cmds.push_back(cmd(FUNC_ADD, 5'd3, 1'b0, 7'd5, 7'd0, 5'd20, 2'd2, 7'd0, 7'd127));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd3, 1'b0, 7'd5, 7'd127, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd3, 1'b0, 7'd5, 7'd0, 5'd0, 2'd0, 7'd0, 7'd0));
      // Omni entry with a reversed range, an out-of-range type and deck three.
      pending_cmds.push_back(cmd(FUNC_ADD, 5'd0, 1'b1, 7'd127, 7'd0, 5'd31, 2'd3, 7'd100,
                                 7'd20));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd16, 1'b1, 7'd127, 7'd60, 5'd0, 2'd0, 7'd0,
                                 7'd0));
      // Scan hit on an entry whose range is a single value.
      pending_cmds.push_back(cmd(FUNC_ADD, 5'd9, 1'b0, 7'd6, 7'd0, 5'd1, 2'd1, 7'd64, 7'd64));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd2, 1'b0, 7'd6, 7'd64, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd2, 1'b0, 7'd6, 7'd63, 5'd0, 2'd0, 7'd0, 7'd0));
      // Channels above sixteen and the undefined command codes do nothing.
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd17, 1'b0, 7'd5, 7'd9, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd31, 1'b1, 7'd5, 7'd9, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_ADD, 5'd31, 1'b0, 7'd9, 7'd0, 5'd2, 2'd1, 7'd0, 7'd9));
      pending_cmds.push_back(cmd(3'd6, 5'd1, 1'b0, 7'd9, 7'd9, 5'd2, 2'd1, 7'd0, 7'd9));
      pending_cmds.push_back(cmd(3'd7, 5'd1, 1'b0, 7'd9, 7'd9, 5'd2, 2'd1, 7'd0, 7'd9));
      // An arm that times out after two ticks, then a miss.
      pending_cmds.push_back(cmd(FUNC_ARM, 5'd0, 1'b0, 7'd0, 7'd0, 5'd7, 2'd1, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_TICK, 5'd0, 1'b0, 7'd0, 7'd0, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_TICK, 5'd0, 1'b0, 7'd0, 7'd0, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd1, 1'b1, 7'd9, 7'd1, 5'd0, 2'd0, 7'd0, 7'd0));
      // Arming with an unknown type does not arm; a real arm is then learned.
      pending_cmds.push_back(cmd(FUNC_ARM, 5'd0, 1'b0, 7'd0, 7'd0, 5'd21, 2'd3, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_ARM, 5'd0, 1'b0, 7'd0, 7'd0, 5'd4, 2'd2, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd1, 1'b1, 7'd9, 7'd1, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd1, 1'b1, 7'd9, 7'd100, 5'd0, 2'd0, 7'd0,
                                 7'd0));
      // Remove, then clear all.
      pending_cmds.push_back(cmd(FUNC_REMOVE, 5'd9, 1'b0, 7'd6, 7'd0, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd2, 1'b0, 7'd6, 7'd64, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_CLEAR, 5'd0, 1'b0, 7'd0, 7'd0, 5'd0, 2'd0, 7'd0, 7'd0));
      pending_cmds.push_back(cmd(FUNC_MIDI, 5'd3, 1'b0, 7'd5, 7'd127, 5'd0, 2'd0, 7'd0, 7'd0));
      wait_drained();

      // Random phases over several register settings and gap rates.
      csr_write(REG_LEARN_TIMEOUT, 32'd5);
      run_random(0);
      csr_write(REG_GLOBAL_CHANNEL, 32'd1);
      csr_write(REG_LEARN_TIMEOUT, 32'd1);
      run_random(48);
      csr_write(REG_ENGINE_ENABLE, 32'd0);
      csr_write(REG_LEARN_ENABLE, 32'd0);
      csr_write(REG_GLOBAL_CHANNEL, 32'd16);
      run_random(27);
      csr_write(REG_ENGINE_ENABLE, 32'd1);
      csr_write(REG_LEARN_ENABLE, 32'd1);
      csr_write(REG_LEARN_TIMEOUT, 32'd65535);
      run_random(0);
      csr_write(REG_GLOBAL_CHANNEL, 32'd0);
      csr_write(REG_LEARN_TIMEOUT, 32'd3);
      run_random(48);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
